// ===== rtl/core/optimal_cache_replacement_core_defines.svh =====
// assertion macros shared by the core
`ifndef OPTIMAL_CACHE_REPLACEMENT_CORE_DEFINES_SVH
`define OPTIMAL_CACHE_REPLACEMENT_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OCR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ocr assertion failed");

// next-cycle implication, disabled during reset
`define OCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ocr assertion failed");

`endif

// ===== rtl/core/ocr_pkg.sv =====
`default_nettype none

package ocr_pkg;

  // fixed field widths
  localparam int KEY_W  = 32;
  localparam int SLOT_W = 5;
  localparam int CFG_W  = 5;

  // active ways after reset
  localparam logic [CFG_W-1:0] ACTIVE_WAYS_RESET = 5'd16;

endpackage

`default_nettype wire

// ===== rtl/core/ocr_if.sv =====
`default_nettype none

// request channel: key and its next-use time
interface ocr_req_if #(
  parameter int TIME_BITS = 20
) ();
  import ocr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KEY_W-1:0]     req_key;
  logic [TIME_BITS-1:0] next_use;

  modport source (output valid, req_key, next_use, input ready);
  modport sink   (input valid, req_key, next_use, output ready);
endinterface

// result channel: hit flag and one-based slot
interface ocr_resp_if ();
  import ocr_pkg::*;

  logic              valid;
  logic              ready;
  logic              was_hit;
  logic [SLOT_W-1:0] slot_used;

  modport source (output valid, was_hit, slot_used, input ready);
  modport sink   (input valid, was_hit, slot_used, output ready);
endinterface

// configuration write channel for active_ways
interface ocr_cfg_if ();
  import ocr_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/optimal_cache_replacement_core.sv =====
// channel  role    beat contents
// -------  ------  --------------------------------------
// req      sink    req_key, next_use
// resp     source  was_hit, slot_used
// cfg      sink    data (active_ways), always ready
//
// one request per cycle sustained while resp does not stall; a request moves from the input
// register to the result register through the tag compare and max tree
// a request beat loads the input register, which then loads the result register; result beat follows
// rst (synchronous) clears the fill count, valid flags and active_ways to 16
// resp stalls hold the result register; req stays ready while the input
// register can drain into it in the same cycle
`default_nettype none
`include "optimal_cache_replacement_core_defines.svh"

module optimal_cache_replacement_core #(
  parameter int WAYS      = 16,
  parameter int TIME_BITS = 20
) (
  input wire logic    clk,
  input wire logic    rst,
  ocr_req_if.sink     req,
  ocr_resp_if.source  resp,
  ocr_cfg_if.sink     cfg
);
  import ocr_pkg::*;

  localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW = $clog2(WAYS + 1);

  // configuration and control state
  logic [CFG_W-1:0]     active_ways;
  logic [CW-1:0]        filled_count;
  logic [CW-1:0]        filled_count_next;
  logic [CW-1:0]        ways_eff;

  // slot storage, undefined until written
  logic [KEY_W-1:0]     slot_tag      [WAYS];
  logic [TIME_BITS-1:0] slot_next_use [WAYS];

  // input register
  logic                 req_valid_q;
  logic [KEY_W-1:0]     req_key_q;
  logic [TIME_BITS-1:0] req_nu_q;

  // result register
  logic                 resp_valid_q;
  logic                 was_hit_q;
  logic [SLOT_W-1:0]    slot_used_q;

  logic                 fire;
  logic                 hit;
  logic [IW-1:0]        hit_idx;
  logic [WAYS-1:0]      elig;
  logic [IW-1:0]        victim_idx;
  logic [TIME_BITS-1:0] far;
  logic                 do_fill;
  logic                 wr_en;
  logic [IW-1:0]        wr_idx;
  logic                 was_hit_next;
  logic [SLOT_W-1:0]    slot_used_next;

  // handshakes
  assign fire      = req_valid_q && (!resp_valid_q || resp.ready);
  assign req.ready = !req_valid_q || fire;
  assign cfg.ready = 1'b1;

  assign resp.valid     = resp_valid_q;
  assign resp.was_hit   = was_hit_q;
  assign resp.slot_used = slot_used_q;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_ways <= ACTIVE_WAYS_RESET;
    end else if (cfg.valid) begin
      active_ways <= cfg.data;
    end
  end

  // clamp active ways into 1..WAYS
  always_comb begin
    if (active_ways == '0) begin
      ways_eff = CW'(1);
    end else if (32'(active_ways) > 32'(WAYS)) begin
      ways_eff = CW'(WAYS);
    end else begin
      ways_eff = CW'(active_ways);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid_q <= 1'b0;
    end else if (req.ready) begin
      req_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_key_q <= req.req_key;
      req_nu_q  <= req.next_use;
    end
  end

  // tag compare
  ocr_lookup #(
    .WAYS (WAYS)
  ) u_lookup (
    .tags         (slot_tag),
    .filled_count (filled_count),
    .key          (req_key_q),
    .hit          (hit),
    .hit_idx      (hit_idx)
  );

  // victim candidates are the active slots
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      elig[i] = (32'(ways_eff) > i);
    end
  end

  ocr_victim #(
    .WAYS      (WAYS),
    .TIME_BITS (TIME_BITS)
  ) u_victim (
    .times      (slot_next_use),
    .elig       (elig),
    .victim_idx (victim_idx),
    .far        (far)
  );

  // hit, fill, replace or bypass
  always_comb begin
    do_fill           = !hit && (filled_count < ways_eff);
    filled_count_next = filled_count;
    wr_en             = 1'b0;
    wr_idx            = hit_idx;
    was_hit_next      = hit;
    slot_used_next    = SLOT_W'((IW+1)'(hit_idx) + (IW+1)'(1));
    if (hit) begin
      wr_en = 1'b1;
    end else if (do_fill) begin
      wr_en             = 1'b1;
      wr_idx            = filled_count[IW-1:0];
      filled_count_next = filled_count + CW'(1);
      slot_used_next    = SLOT_W'((IW+1)'(filled_count[IW-1:0]) + (IW+1)'(1));
    end else if (req_nu_q < far) begin
      wr_en          = 1'b1;
      wr_idx         = victim_idx;
      slot_used_next = SLOT_W'((IW+1)'(victim_idx) + (IW+1)'(1));
    end else begin
      slot_used_next = '0;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      filled_count <= '0;
    end else if (fire) begin
      filled_count <= filled_count_next;
    end
  end

  // slot write, a hit rewrites its own tag unchanged
  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      slot_tag[wr_idx]      <= req_key_q;
      slot_next_use[wr_idx] <= req_nu_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid_q <= 1'b0;
    end else if (fire) begin
      resp_valid_q <= 1'b1;
    end else if (resp.ready) begin
      resp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      was_hit_q   <= was_hit_next;
      slot_used_q <= slot_used_next;
    end
  end

  // checks
  `OCR_ASSERT_NEXT(a_fill_step, clk, rst, fire && do_fill, filled_count == $past(filled_count) + CW'(1))
  `OCR_ASSERT_NEXT(a_hit_keeps_fill, clk, rst, fire && hit, filled_count == $past(filled_count))
  `OCR_ASSERT_NEXT(a_req_held, clk, rst, req_valid_q && !fire, req_valid_q)
  `OCR_ASSERT_NOW(a_fill_bound, clk, rst, fire && do_fill, filled_count < ways_eff && !hit)

endmodule

`default_nettype wire

// ===== rtl/core/ocr_lookup.sv =====
`default_nettype none

// parallel tag compare over the filled slots
module ocr_lookup #(
  parameter int WAYS = 16
) (
  input  logic [ocr_pkg::KEY_W-1:0] tags [WAYS],
  input  logic [$clog2(WAYS+1)-1:0] filled_count,
  input  logic [ocr_pkg::KEY_W-1:0] key,
  output logic                      hit,
  output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] hit_idx
);
  import ocr_pkg::*;

  localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW = $clog2(WAYS + 1);

  logic [WAYS-1:0] match;

  // per-slot compare, only slots below the fill count are valid
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = (tags[i] == key) && (CW'(i) < filled_count);
    end
  end

  // tags are unique, so an or of the matching indexes gives the slot
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign hit = |match;

endmodule

`default_nettype wire

// ===== rtl/core/ocr_victim.sv =====
`default_nettype none

// max tree over next-use times, lowest slot wins a tie
module ocr_victim #(
  parameter int WAYS      = 16,
  parameter int TIME_BITS = 20
) (
  input  logic [TIME_BITS-1:0] times [WAYS],
  input  logic [WAYS-1:0]      elig,
  output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] victim_idx,
  output logic [TIME_BITS-1:0] far
);

  localparam int IW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LEAVES = 1 << IW;
  localparam int NODES  = 2 * LEAVES - 1;

  logic                 node_valid [NODES];
  logic [TIME_BITS-1:0] node_time  [NODES];
  logic [IW-1:0]        node_idx   [NODES];

  // leaves, padding beyond the slot count never wins
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < WAYS) begin : g_real
      assign node_valid[LEAVES-1+i] = elig[i];
      assign node_time[LEAVES-1+i]  = times[i];
      assign node_idx[LEAVES-1+i]   = IW'(i);
    end else begin : g_pad
      assign node_valid[LEAVES-1+i] = 1'b0;
      assign node_time[LEAVES-1+i]  = '0;
      assign node_idx[LEAVES-1+i]   = '0;
    end
  end

  // inner nodes take the right child only when strictly farther
  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
    logic pick_r;
    assign pick_r = node_valid[2*n+2] &&
                    (!node_valid[2*n+1] || (node_time[2*n+2] > node_time[2*n+1]));
    assign node_valid[n] = node_valid[2*n+1] | node_valid[2*n+2];
    assign node_time[n]  = pick_r ? node_time[2*n+2] : node_time[2*n+1];
    assign node_idx[n]   = pick_r ? node_idx[2*n+2]  : node_idx[2*n+1];
  end

  assign victim_idx = node_idx[0];
  assign far        = node_time[0];

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ocr_pkg::*;

  localparam int WAYS        = 16;
  localparam int TIME_BITS   = 20;
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_DEPTH  = 48;
  localparam int PHASE_ITEMS = 135;

  localparam logic [TIME_BITS-1:0] NEVER_AGAIN = '1;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } lookup_t;

  logic clk;
  logic rst;

  ocr_req_if #(.TIME_BITS(TIME_BITS)) req_ch ();
  ocr_resp_if resp_ch ();
  ocr_cfg_if  cfg_ch ();

  optimal_cache_replacement_core #(
    .WAYS      (WAYS),
    .TIME_BITS (TIME_BITS)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .req  (req_ch),
    .resp (resp_ch),
    .cfg  (cfg_ch)
  );

  // shadow copy of the cache contents
  logic [KEY_W-1:0]     shadow_tag  [WAYS];
  logic [TIME_BITS-1:0] shadow_next [WAYS];
  int                   shadow_filled;
  logic [CFG_W-1:0]     shadow_ways;

  lookup_t          pending_lookups [$];
  int               mismatches;
  int               quiet_cycles;
  bit               send_gaps;
  bit               recv_gaps;
  bit               hold_off_req;
  logic [KEY_W-1:0] key_pool [POOL_DEPTH];
  int               pool_size;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // belady lookup on the shadow cache: hit, fill, evict or bypass
  function automatic lookup_t cache_lookup(input logic [KEY_W-1:0] key,
                                           input logic [TIME_BITS-1:0] when_next);
    lookup_t              r;
    int                   ways;
    int                   lim;
    int                   victim;
    int                   i;
    logic [TIME_BITS-1:0] farthest;
    ways = int'(shadow_ways);
    if (ways == 0) ways = 1;
    if (ways > WAYS) ways = WAYS;
    r.hit  = 1'b0;
    r.slot = '0;
    for (i = 0; i < shadow_filled; i++) begin
      if (shadow_tag[i] == key) begin
        shadow_next[i] = when_next;
        r.hit  = 1'b1;
        r.slot = SLOT_W'(i + 1);
        return r;
      end
    end
    // free slot while below the active count
    if (shadow_filled < ways) begin
      shadow_tag[shadow_filled]  = key;
      shadow_next[shadow_filled] = when_next;
      shadow_filled++;
      r.slot = SLOT_W'(shadow_filled);
      return r;
    end
    // farthest next use among active slots, lowest slot wins a tie
    lim      = (shadow_filled < ways) ? shadow_filled : ways;
    victim   = 0;
    farthest = shadow_next[0];
    for (i = 1; i < lim; i++) begin
      if (shadow_next[i] > farthest) begin
        farthest = shadow_next[i];
        victim   = i;
      end
    end
    if (when_next >= farthest) return r;
    shadow_tag[victim]  = key;
    shadow_next[victim] = when_next;
    r.slot = SLOT_W'(victim + 1);
    return r;
  endfunction

  // check result beats, then track config and request beats
  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      shadow_filled = 0;
      shadow_ways   = ACTIVE_WAYS_RESET;
    end else begin
      if (resp_ch.valid && resp_ch.ready) begin
        if (pending_lookups.size() == 0) begin
          $error("result beat with nothing pending: was_hit %0d slot_used %0d",
                 resp_ch.was_hit, resp_ch.slot_used);
          mismatches++;
        end else begin
          want = pending_lookups.pop_front();
          if (resp_ch.was_hit !== want.hit) begin
            $error("was_hit: expected %0d, actual %0d", want.hit, resp_ch.was_hit);
            mismatches++;
          end
          if (resp_ch.slot_used !== want.slot) begin
            $error("slot_used: expected %0d, actual %0d", want.slot, resp_ch.slot_used);
            mismatches++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) shadow_ways = cfg_ch.data;
      if (req_ch.valid && req_ch.ready)
        pending_lookups.insert(pending_lookups.size(),
                               cache_lookup(req_ch.req_key, req_ch.next_use));
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("optimal_cache_replacement_core regression: fail");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    resp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = recv_gaps ? $urandom_range(0, 18) : 0;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        resp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      resp_ch.ready <= 1'b1;
      do @(posedge clk); while (!resp_ch.valid);
    end
  end

  // one request beat, valid left high for a back-to-back follower
  task automatic send_request(input logic [KEY_W-1:0] key,
                              input logic [TIME_BITS-1:0] when_next);
    int gap;
    gap = send_gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_key  <= key;
    req_ch.next_use <= when_next;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // stop requesting and wait for every pending result
  task automatic drain_lookups();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  // active_ways write, only with the block idle
  task automatic set_active_ways(input logic [CFG_W-1:0] ways);
    drain_lookups();
    repeat (3) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= ways;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // requests over the key pool plus fresh keys; times mixed for ties and never
  task automatic random_requests(input int count);
    logic [KEY_W-1:0]     key;
    logic [TIME_BITS-1:0] when_next;
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, pool_size - 1)];
      case ($urandom_range(0, 7))
        0:       when_next = NEVER_AGAIN;
        1, 2:    when_next = TIME_BITS'($urandom_range(0, 15));
        default: when_next = TIME_BITS'($urandom);
      endcase
      send_request(key, when_next);
    end
  endtask

  // fill, hit, bypass on never and on equal time, eviction with a tie,
  // active count zero and above range, hit beyond the active count
  task automatic test_directed();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    set_active_ways(5'd2);
    send_request(32'h0000_0000, 20'd5);
    send_request(32'hFFFF_FFFF, NEVER_AGAIN);
    send_request(32'h0000_0000, 20'd7);
    send_request(32'h1234_5678, NEVER_AGAIN);
    send_request(32'hA5A5_A5A5, 20'd0);
    send_request(32'h0000_0003, 20'd7);
    send_request(32'h0000_0003, 20'd6);
    send_request(32'hA5A5_A5A5, 20'd6);
    send_request(32'h0000_0009, 20'd1);
    set_active_ways(5'd0);
    send_request(32'hA5A5_A5A5, 20'd2);
    send_request(32'hDEAD_BEEF, 20'd0);
    send_request(32'h0BAD_F00D, 20'h80000);
    set_active_ways(5'd31);
    send_request(32'h5A5A_5A5A, 20'd1);
    send_request(32'hDEAD_BEEF, NEVER_AGAIN);
  endtask

  // random traffic over several active counts, lowered after filling too
  task automatic test_random_phases();
    logic [CFG_W-1:0] phase_ways [8];
    int               eff;
    int               p;
    phase_ways = '{5'd4, 5'd16, 5'd1, 5'd8, 5'd0, 5'd31, 5'd0, 5'd0};
    phase_ways[6] = CFG_W'($urandom_range(1, 16));
    phase_ways[7] = CFG_W'($urandom);
    for (p = 0; p < 8; p++) begin
      set_active_ways(phase_ways[p]);
      eff = int'(phase_ways[p]);
      if (eff == 0) eff = 1;
      if (eff > WAYS) eff = WAYS;
      pool_size = (2 * eff + 4 > POOL_DEPTH) ? POOL_DEPTH : 2 * eff + 4;
      if (p == 0) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end else if (p == 1) begin
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
      end else begin
        send_gaps = $urandom_range(0, 2) != 0;
        recv_gaps = $urandom_range(0, 2) != 0;
      end
      random_requests(PHASE_ITEMS);
    end
  endtask

  // result side holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    set_active_ways(5'd16);
    pool_size = 40;
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    hold_off_req = 1'b1;
    random_requests(60);
  endtask

  // stimulus
  initial begin
    int i;
    mismatches     = 0;
    quiet_cycles   = 0;
    hold_off_req   = 1'b0;
    send_gaps      = 1'b0;
    recv_gaps      = 1'b0;
    pool_size      = 8;
    for (i = 0; i < POOL_DEPTH; i++) key_pool[i] = $urandom;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_key  <= '0;
    req_ch.next_use <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_phases();
    test_backpressure();

    drain_lookups();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("optimal_cache_replacement_core regression: pass");
    end else begin
      $display("optimal_cache_replacement_core regression: fail");
    end
    $finish;
  end

endmodule
